// File: hw/rtl/orma_pkg.sv
// orma_pkg: shared types and constants for the outlier rejecting moving average.
// Holds register indexes, field widths, reset values and the sequencer state type.
// No dependencies.
package orma_pkg;

	localparam int WINDOW_MAX_DEF   = 64;
	localparam int SAMPLE_WIDTH_DEF = 16;

	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam int WS_W      = 7;
	localparam int THR_W     = 16;
	localparam int OVR_W     = 8;
	localparam int TALLY_W   = 8;

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OVERRIDE    = 2'd2;

	localparam logic [WS_W-1:0]  WS_RESET  = 7'd8;
	localparam logic [THR_W-1:0] THR_RESET = 16'd100;
	localparam logic [OVR_W-1:0] OVR_RESET = 8'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV_OV,
		ST_PUT,
		ST_DIV_MEAN,
		ST_DONE
	} orma_state_t;

endpackage

// File: hw/rtl/outlier_rejecting_moving_average_core.sv
// outlier_rejecting_moving_average_core: moving average over a sample ring with outlier rejection.
// Per input: ring read, outlier check once filled, override mean division when the run limit is hit,
// ring write, mean division; a rejected outlier skips these. One item at a time, next input transfer
// in the cycle after the result is loaded. Divisions run in orma_div, one quotient bit per cycle.
// Reset (and a window size write) clears sum, run and fill state; ring entries read as zero.
// Depends on orma_pkg, orma_ring, orma_div.
module outlier_rejecting_moving_average_core
	import orma_pkg::*;
#(
	parameter int WINDOW_MAX   = WINDOW_MAX_DEF,
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write_en,
	input  logic [CFG_IDX_W-1:0]           cfg_index,
	input  logic [CFG_W-1:0]               cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           accepted,
	output logic signed [SAMPLE_WIDTH-1:0] average,
	output logic [TALLY_W-1:0]             outlier_run
);

	localparam int SW       = SAMPLE_WIDTH;
	localparam int AW       = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int WP_W     = $clog2(WINDOW_MAX + 1);
	localparam int SUM_W    = SW + $clog2(WINDOW_MAX) + 1;
	localparam int TOT_W    = SW + TALLY_W + 1;
	localparam int DVD_W    = (SUM_W > TOT_W) ? SUM_W : TOT_W;
	localparam int DVS_W    = (WP_W > TALLY_W) ? WP_W : TALLY_W;
	localparam int CMP_W    = (SW + 1 > THR_W) ? SW + 1 : THR_W;
	localparam int RESET_WP = (int'(WS_RESET) > WINDOW_MAX) ? WINDOW_MAX : int'(WS_RESET);

	function automatic logic [WP_W-1:0] win_eff(input logic [WS_W-1:0] ws);
		logic [31:0] w;
		w = 32'(ws);
		if (ws == '0) return WP_W'(1);
		if (w > 32'(WINDOW_MAX)) return WP_W'(WINDOW_MAX);
		return WP_W'(ws);
	endfunction

	orma_state_t state_q, state_d;

	logic [WS_W-1:0]         ws_q;
	logic [THR_W-1:0]        thr_q;
	logic [OVR_W-1:0]        ovr_q;
	logic [WP_W-1:0]         wp_q;
	logic                    filled_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [TALLY_W-1:0]      tally_q;
	logic signed [TOT_W-1:0] total_q;
	logic signed [SW-1:0]    mean_q;
	logic                    acc_q;
	logic signed [SW-1:0]    x_q;
	logic signed [SW-1:0]    v_q;
	logic                    out_valid_q;
	logic                    acc_out_q;
	logic signed [SW-1:0]    avg_q;
	logic [TALLY_W-1:0]      run_q;

	logic [WP_W-1:0]         eff_w;
	logic [WP_W-1:0]         base_wp;
	logic [WP_W-1:0]         new_wp;
	logic [AW-1:0]           put_idx;
	logic [AW-1:0]           last_idx;
	logic [OVR_W-1:0]        eff_ov;
	logic [TALLY_W:0]        tally_n;
	logic signed [TOT_W-1:0] total_n;
	logic signed [SUM_W-1:0] sum_n;
	logic signed [SW:0]      dmean_s;
	logic signed [SW:0]      dlast_s;
	logic [SW:0]             dmean;
	logic [SW:0]             dlast;
	logic                    outlier;
	logic                    ov_fire;
	logic                    win_wr;

	logic                    ring_re;
	logic [AW-1:0]           ring_raddr;
	logic signed [SW-1:0]    ring_rd;
	logic                    ring_we;

	logic                    div_start;
	logic signed [DVD_W-1:0] div_dividend;
	logic [DVS_W-1:0]        div_divisor;
	logic                    div_busy;
	logic                    div_done;
	logic signed [DVD_W-1:0] div_quot;
	logic                    out_load;

	assign eff_w    = win_eff(ws_q);
	assign base_wp  = (wp_q == '0 || wp_q > eff_w) ? eff_w : wp_q;
	assign new_wp   = base_wp - WP_W'(1);
	assign put_idx  = new_wp[AW-1:0];
	assign last_idx = wp_q[AW-1:0];
	assign eff_ov   = (ovr_q == '0) ? OVR_W'(1) : ovr_q;
	assign tally_n  = {1'b0, tally_q} + (TALLY_W + 1)'(1);
	assign total_n  = total_q + TOT_W'(x_q);
	assign sum_n    = sum_q - SUM_W'(ring_rd) + SUM_W'(v_q);
	assign dmean_s  = (SW + 1)'(x_q) - (SW + 1)'(mean_q);
	assign dlast_s  = (SW + 1)'(x_q) - (SW + 1)'(ring_rd);
	assign dmean    = dmean_s[SW] ? (SW + 1)'(-dmean_s) : (SW + 1)'(dmean_s);
	assign dlast    = dlast_s[SW] ? (SW + 1)'(-dlast_s) : (SW + 1)'(dlast_s);
	assign outlier  = (CMP_W'(dmean) > CMP_W'(thr_q)) && (CMP_W'(dlast) > CMP_W'(thr_q));
	assign ov_fire  = tally_n >= {1'b0, eff_ov};
	assign win_wr   = cfg_write_en && cfg_index == REG_WINDOW_SIZE;

	orma_ring #(
		.DEPTH (WINDOW_MAX),
		.AW    (AW),
		.DW    (SW)
	) u_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.clear   (win_wr),
		.rd_en   (ring_re),
		.rd_addr (ring_raddr),
		.rd_data (ring_rd),
		.wr_en   (ring_we),
		.wr_addr (put_idx),
		.wr_data (v_q)
	);

	orma_div #(
		.DVD_W (DVD_W),
		.DVS_W (DVS_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quot)
	);

	always_comb begin
		state_d      = state_q;
		in_ready     = 1'b0;
		ring_re      = 1'b0;
		ring_raddr   = put_idx;
		ring_we      = 1'b0;
		div_start    = 1'b0;
		div_dividend = DVD_W'(sum_n);
		div_divisor  = DVS_W'(eff_w);
		out_load     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ring_re    = 1'b1;
					ring_raddr = filled_q ? last_idx : put_idx;
					state_d    = filled_q ? ST_CHECK : ST_PUT;
				end
			end
			ST_CHECK: begin
				if (!outlier) begin
					ring_re = 1'b1;
					state_d = ST_PUT;
				end else if (ov_fire) begin
					div_start    = 1'b1;
					div_dividend = DVD_W'(total_n);
					div_divisor  = DVS_W'(tally_n[TALLY_W-1:0]);
					state_d      = ST_DIV_OV;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_DIV_OV: begin
				if (div_done) begin
					ring_re = 1'b1;
					state_d = ST_PUT;
				end
			end
			ST_PUT: begin
				ring_we   = 1'b1;
				div_start = 1'b1;
				state_d   = ST_DIV_MEAN;
			end
			ST_DIV_MEAN: begin
				if (div_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_q        <= WS_RESET;
			thr_q       <= THR_RESET;
			ovr_q       <= OVR_RESET;
			wp_q        <= WP_W'(RESET_WP);
			filled_q    <= 1'b0;
			sum_q       <= '0;
			tally_q     <= '0;
			total_q     <= '0;
			mean_q      <= '0;
			acc_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_IDLE && in_valid) begin
				acc_q <= 1'b0;
			end
			if (state_q == ST_CHECK) begin
				if (!outlier || ov_fire) begin
					tally_q <= '0;
					total_q <= '0;
				end else begin
					tally_q <= tally_n[TALLY_W-1:0];
					total_q <= total_n;
				end
			end
			if (state_q == ST_PUT) begin
				wp_q  <= new_wp;
				sum_q <= sum_n;
				acc_q <= 1'b1;
				if (wp_q == '0) begin
					filled_q <= 1'b1;
				end
			end
			if (state_q == ST_DIV_MEAN && div_done) begin
				mean_q <= div_quot[SW-1:0];
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_write_en) begin
				case (cfg_index)
					REG_WINDOW_SIZE: begin
						ws_q     <= cfg_data[WS_W-1:0];
						wp_q     <= win_eff(cfg_data[WS_W-1:0]);
						filled_q <= 1'b0;
						sum_q    <= '0;
						tally_q  <= '0;
						total_q  <= '0;
						mean_q   <= '0;
					end
					REG_THRESHOLD: begin
						thr_q <= cfg_data[THR_W-1:0];
					end
					REG_OVERRIDE: begin
						ovr_q <= cfg_data[OVR_W-1:0];
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			x_q <= sample;
			v_q <= sample;
		end
		if (state_q == ST_DIV_OV && div_done) begin
			v_q <= div_quot[SW-1:0];
		end
		if (out_load) begin
			acc_out_q <= acc_q;
			avg_q     <= mean_q;
			run_q     <= tally_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign accepted    = acc_out_q;
	assign average     = avg_q;
	assign outlier_run = run_q;

	a_wp_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		filled_q |-> wp_q < eff_w)
		else $error("write position outside window while ring filled");

	a_put_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		ring_we |-> new_wp < eff_w)
		else $error("ring write outside window");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV_OV || state_q == ST_DIV_MEAN))
		else $error("divider finished outside a wait state");

	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider started while busy");

endmodule

// File: hw/rtl/orma_ring.sv
// orma_ring: sample ring memory, one write and one registered read port.
// Per-entry valid flags make unwritten entries read as zero after reset or clear.
// No dependencies.
module orma_ring #(
	parameter int DEPTH = 64,
	parameter int AW    = 6,
	parameter int DW    = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          clear,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data
);

	logic [DW-1:0]    mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [DW-1:0]    rd_q;
	logic             rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (clear) begin
				vld_q <= '0;
			end else if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_q : '0;

endmodule

// File: hw/rtl/orma_div.sv
// orma_div: iterative signed-by-unsigned divider, quotient truncated toward zero.
// Restoring, one quotient bit per cycle; done pulses in the cycle after the last bit.
// No dependencies.
module orma_div #(
	parameter int DVD_W = 25,
	parameter int DVS_W = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0]        divisor,
	output logic                    busy,
	output logic                    done,
	output logic signed [DVD_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic             neg_q;
	logic [DVD_W-1:0] q_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;

	logic [DVD_W-1:0] mag;
	logic [DVS_W:0]   shifted;
	logic [DVS_W:0]   diff;
	logic             ge;
	logic             last;

	assign mag     = dividend[DVD_W-1] ? DVD_W'(-dividend) : DVD_W'(dividend);
	assign shifted = {rem_q, q_q[DVD_W-1]};
	assign diff    = shifted - {1'b0, dvs_q};
	assign ge      = shifted >= {1'b0, dvs_q};
	assign last    = cnt_q == CNT_W'(DVD_W - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && last;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[DVD_W-1];
			q_q   <= mag;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			q_q   <= {q_q[DVD_W-2:0], ge};
			rem_q <= ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = neg_q ? -$signed(q_q) : $signed(q_q);

endmodule
